@@ rtl/terrain_cell_obstacle_classifier_core_assert.svh @@
// ----------------------------------------------------------------------------
// terrain cell obstacle classifier assertion macros
// concurrent check wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef TERRAIN_CELL_OBSTACLE_CLASSIFIER_CORE_ASSERT_SVH
`define TERRAIN_CELL_OBSTACLE_CLASSIFIER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while reset is asserted
`define TCOC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcoc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TCOC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcoc assertion failed");

`else

`define TCOC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define TCOC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/tcoc_pkg.sv @@
// ----------------------------------------------------------------------------
// tcoc_pkg
// shared types, codes and reset values of the terrain cell classifier
// ----------------------------------------------------------------------------
package tcoc_pkg;

    // register indexes
    localparam logic [2:0] CFG_MIN_EVIDENCE  = 3'd0;
    localparam logic [2:0] CFG_MIN_POINTS    = 3'd1;
    localparam logic [2:0] CFG_CLEAR_FLOOR   = 3'd2;
    localparam logic [2:0] CFG_OVH_CLEAR     = 3'd3;
    localparam logic [2:0] CFG_RISE_LIMIT    = 3'd4;
    localparam logic [2:0] CFG_DROP_LIMIT    = 3'd5;
    localparam logic [2:0] CFG_MAX_SLOPE     = 3'd6;
    localparam logic [2:0] CFG_MAX_ROUGHNESS = 3'd7;

    // register reset values
    localparam logic [15:0] RST_MIN_EVIDENCE  = 16'd256;
    localparam logic [7:0]  RST_MIN_POINTS    = 8'd4;
    localparam logic [14:0] RST_CLEAR_FLOOR   = 15'd500;
    localparam logic [15:0] RST_OVH_CLEAR     = 16'd128;
    localparam logic [14:0] RST_RISE_LIMIT    = 15'd150;
    localparam logic [14:0] RST_DROP_LIMIT    = 15'd200;
    localparam logic [13:0] RST_MAX_SLOPE     = 14'd2500;
    localparam logic [15:0] RST_MAX_ROUGHNESS = 16'd50;

    // height code for a value that is not finite
    localparam logic [15:0] NOT_FINITE_MM = 16'h8000;

    // block reason codes
    localparam logic [2:0] REASON_NONE       = 3'd0;
    localparam logic [2:0] REASON_LOW_CLEAR  = 3'd1;
    localparam logic [2:0] REASON_GEOMETRY   = 3'd2;
    localparam logic [2:0] REASON_PROTRUSION = 3'd3;
    localparam logic [2:0] REASON_MIXED      = 3'd4;

    // protrusion / overhead stage codes
    localparam logic [1:0] STAGE_NONE  = 2'd0;
    localparam logic [1:0] STAGE_LOW   = 2'd1;
    localparam logic [1:0] STAGE_BLOCK = 2'd2;

    // publish status codes
    localparam logic [2:0] PUB_NA           = 3'd0;
    localparam logic [2:0] PUB_PROTRUSION   = 3'd1;
    localparam logic [2:0] PUB_DENSE        = 3'd2;
    localparam logic [2:0] PUB_OVERHEAD     = 3'd3;
    localparam logic [2:0] PUB_GEOMETRY     = 3'd4;
    localparam logic [2:0] PUB_GATED_EVID   = 3'd5;
    localparam logic [2:0] PUB_GATED_HEIGHT = 3'd6;

    typedef struct packed {
        logic [15:0] min_evidence;
        logic [7:0]  min_points;
        logic [14:0] clear_floor;
        logic [15:0] overhead_clear_level;
        logic [14:0] rise_limit;
        logic [14:0] drop_limit;
        logic [13:0] max_slope;
        logic [15:0] max_roughness;
    } t_cfg;

    typedef struct packed {
        logic [15:0]        protrusion_level;
        logic [15:0]        overhead_level;
        logic [15:0]        overhead_trust;
        logic signed [15:0] clearance_mm;
        logic [13:0]        slope_cdeg;
        logic signed [15:0] rise_mm;
        logic signed [15:0] drop_mm;
        logic [15:0]        rough_level;
        logic signed [15:0] protrusion_rel_mm;
        logic signed [15:0] candidate_rel_mm;
        logic [7:0]         sample_count;
        logic [15:0]        frame_gain;
    } t_cell;

    // compare stage results
    typedef struct packed {
        logic               dense;
        logic               prot_high;
        logic               ovh_high;
        logic               low_geom;
        logic               clear_tall;
        logic               geom_fail;
        logic               prot_nz;
        logic               ref_fin;
        logic signed [15:0] ref_mm;
        logic [15:0]        sig;
    } t_cmp;

    // decide stage results
    typedef struct packed {
        logic       dense;
        logic       prot_high;
        logic       ovh_high;
        logic       clear_tall;
        logic       geom_fail;
        logic       low_clear;
        logic       prot_block;
        logic       geom_pub;
        logic [1:0] pstage;
        logic [1:0] ostage;
    } t_dec;

    typedef struct packed {
        logic [2:0] blk_cause;
        logic [1:0] prot_grade;
        logic [1:0] ovh_grade;
        logic [2:0] pub_code;
    } t_result;

endpackage

@@ rtl/tcoc_cell_if.sv @@
// ----------------------------------------------------------------------------
// tcoc_cell_if
// input channel: one terrain cell per beat
// ----------------------------------------------------------------------------
interface tcoc_cell_if;
    logic        valid;
    logic        ready;
    logic [15:0] protrusion_level;
    logic [15:0] overhead_level;
    logic [15:0] overhead_trust;
    logic [15:0] clearance_mm;
    logic [13:0] slope_cdeg;
    logic [15:0] rise_mm;
    logic [15:0] drop_mm;
    logic [15:0] rough_level;
    logic [15:0] protrusion_rel_mm;
    logic [15:0] candidate_rel_mm;
    logic [7:0]  sample_count;
    logic [15:0] frame_gain;

    modport source (
        output valid, protrusion_level, overhead_level, overhead_trust, clearance_mm,
               slope_cdeg, rise_mm, drop_mm, rough_level, protrusion_rel_mm,
               candidate_rel_mm, sample_count, frame_gain,
        input  ready
    );
    modport sink (
        input  valid, protrusion_level, overhead_level, overhead_trust, clearance_mm,
               slope_cdeg, rise_mm, drop_mm, rough_level, protrusion_rel_mm,
               candidate_rel_mm, sample_count, frame_gain,
        output ready
    );
endinterface

@@ rtl/tcoc_class_if.sv @@
// ----------------------------------------------------------------------------
// tcoc_class_if
// output channel: one classification per beat
// ----------------------------------------------------------------------------
interface tcoc_class_if;
    logic       valid;
    logic       ready;
    logic [2:0] blk_cause;
    logic [1:0] prot_grade;
    logic [1:0] ovh_grade;
    logic [2:0] pub_code;

    modport source (
        output valid, blk_cause, prot_grade, ovh_grade, pub_code,
        input  ready
    );
    modport sink (
        input  valid, blk_cause, prot_grade, ovh_grade, pub_code,
        output ready
    );
endinterface

@@ rtl/tcoc_compare.sv @@
// ----------------------------------------------------------------------------
// tcoc_compare
// first stage: threshold compares, reference height and signal maximum
// ----------------------------------------------------------------------------
module tcoc_compare (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcoc_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    input  tcoc_pkg::t_cell i_cell,
    output logic           o_ready,
    input  logic           i_ready,
    output logic           o_valid,
    output tcoc_pkg::t_cmp o_cmp
);
    import tcoc_pkg::*;

    logic   r_valid;
    t_cmp   r_cmp;
    t_cmp   n_cmp;
    logic [7:0] need;
    logic   clear_fin;
    logic   p_fin;
    logic   c_fin;

    always_comb begin
        need      = (i_cfg.min_points > 8'd1) ? (i_cfg.min_points - 8'd1) : 8'd1;
        clear_fin = i_cell.clearance_mm != NOT_FINITE_MM;
        p_fin     = i_cell.protrusion_rel_mm != NOT_FINITE_MM;
        c_fin     = i_cell.candidate_rel_mm != NOT_FINITE_MM;

        n_cmp.dense = (i_cell.sample_count >= need) && (i_cell.frame_gain != 16'd0)
                      && (i_cell.protrusion_level >= i_cell.frame_gain);
        n_cmp.prot_high  = i_cell.protrusion_level >= i_cfg.min_evidence;
        n_cmp.ovh_high   = i_cell.overhead_level >= i_cfg.min_evidence;
        n_cmp.low_geom   = clear_fin
                           && (i_cell.clearance_mm < $signed({1'b0, i_cfg.clear_floor}));
        n_cmp.clear_tall = clear_fin
                           && (i_cell.clearance_mm > $signed({1'b0, i_cfg.rise_limit}));
        n_cmp.geom_fail  = (i_cell.slope_cdeg > i_cfg.max_slope)
                           || (i_cell.rise_mm > $signed({1'b0, i_cfg.rise_limit}))
                           || (i_cell.drop_mm > $signed({1'b0, i_cfg.drop_limit}))
                           || (i_cell.rough_level > i_cfg.max_roughness);
        n_cmp.prot_nz    = i_cell.protrusion_level != 16'd0;
        n_cmp.ref_fin    = p_fin || c_fin;

        // larger of the finite relative heights
        if (p_fin && c_fin) begin
            n_cmp.ref_mm = (i_cell.protrusion_rel_mm > i_cell.candidate_rel_mm)
                           ? i_cell.protrusion_rel_mm : i_cell.candidate_rel_mm;
        end else if (p_fin) begin
            n_cmp.ref_mm = i_cell.protrusion_rel_mm;
        end else begin
            n_cmp.ref_mm = i_cell.candidate_rel_mm;
        end

        n_cmp.sig = (i_cell.overhead_trust > i_cell.overhead_level)
                    ? i_cell.overhead_trust : i_cell.overhead_level;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmp <= n_cmp;
        end
    end

    assign o_valid = r_valid;
    assign o_cmp   = r_cmp;
endmodule

@@ rtl/tcoc_decide.sv @@
// ----------------------------------------------------------------------------
// tcoc_decide
// second stage: overhead activity, tall test, blocking flags and stages
// ----------------------------------------------------------------------------
module tcoc_decide (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcoc_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    input  tcoc_pkg::t_cmp i_cmp,
    output logic           o_ready,
    input  logic           i_ready,
    output logic           o_valid,
    output tcoc_pkg::t_dec o_dec
);
    import tcoc_pkg::*;

    logic r_valid;
    t_dec r_dec;
    t_dec n_dec;
    logic ovh_active;
    logic tall;
    logic evid;

    always_comb begin
        ovh_active = (i_cmp.sig != 16'd0) && (i_cmp.sig >= i_cfg.overhead_clear_level);
        tall       = i_cmp.ref_fin && (i_cmp.ref_mm > $signed({1'b0, i_cfg.rise_limit}));
        evid       = i_cmp.prot_high || i_cmp.dense;

        n_dec.dense      = i_cmp.dense;
        n_dec.prot_high  = i_cmp.prot_high;
        n_dec.ovh_high   = i_cmp.ovh_high;
        n_dec.clear_tall = i_cmp.clear_tall;
        n_dec.geom_fail  = i_cmp.geom_fail;
        n_dec.low_clear  = i_cmp.low_geom && ovh_active;
        n_dec.prot_block = evid && tall;
        n_dec.geom_pub   = i_cmp.geom_fail && tall && evid;

        if (!i_cmp.prot_nz) begin
            n_dec.pstage = STAGE_NONE;
        end else if (evid && tall) begin
            n_dec.pstage = STAGE_BLOCK;
        end else begin
            n_dec.pstage = STAGE_LOW;
        end

        // nonzero max of trust and level means either one is nonzero
        if (!(i_cmp.sig != 16'd0 || i_cmp.low_geom)) begin
            n_dec.ostage = STAGE_NONE;
        end else if (i_cmp.low_geom && ovh_active) begin
            n_dec.ostage = STAGE_BLOCK;
        end else begin
            n_dec.ostage = STAGE_LOW;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;
endmodule

@@ rtl/tcoc_encode.sv @@
// ----------------------------------------------------------------------------
// tcoc_encode
// last stage: block reason and publish status encode into the output register
// ----------------------------------------------------------------------------
module tcoc_encode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  tcoc_pkg::t_dec    i_dec,
    output logic              o_ready,
    input  logic              i_ready,
    output logic              o_valid,
    output tcoc_pkg::t_result o_result
);
    import tcoc_pkg::*;

    logic    r_valid;
    t_result r_result;
    t_result n_result;

    always_comb begin
        n_result.prot_grade = i_dec.pstage;
        n_result.ovh_grade  = i_dec.ostage;

        if (i_dec.low_clear && i_dec.prot_block) begin
            n_result.blk_cause = REASON_MIXED;
        end else if (i_dec.low_clear) begin
            n_result.blk_cause = REASON_LOW_CLEAR;
        end else if (i_dec.geom_pub && !i_dec.prot_high) begin
            n_result.blk_cause = REASON_GEOMETRY;
        end else if (i_dec.prot_block) begin
            n_result.blk_cause = REASON_PROTRUSION;
        end else if (i_dec.geom_fail) begin
            n_result.blk_cause = REASON_GEOMETRY;
        end else begin
            n_result.blk_cause = REASON_NONE;
        end

        n_result.pub_code = PUB_NA;
        case (n_result.blk_cause)
            REASON_PROTRUSION, REASON_MIXED: begin
                if (i_dec.prot_high) begin
                    n_result.pub_code = PUB_PROTRUSION;
                end else if (i_dec.dense) begin
                    n_result.pub_code = PUB_DENSE;
                end else begin
                    n_result.pub_code = PUB_GATED_EVID;
                end
            end
            REASON_LOW_CLEAR: begin
                if (i_dec.clear_tall) begin
                    n_result.pub_code = i_dec.ovh_high ? PUB_OVERHEAD : PUB_GATED_EVID;
                end else begin
                    n_result.pub_code = PUB_GATED_HEIGHT;
                end
            end
            REASON_GEOMETRY: begin
                if (i_dec.geom_pub) begin
                    n_result.pub_code = PUB_GEOMETRY;
                end
            end
            default: begin
                n_result.pub_code = PUB_NA;
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

@@ rtl/terrain_cell_obstacle_classifier_core.sv @@
// ----------------------------------------------------------------------------
// terrain_cell_obstacle_classifier_core
// classifies one terrain cell per beat into reason, stages and publish status
// ----------------------------------------------------------------------------
// Takes one cell per clock while no stage stalls and passes its classification
// through the compare, decide and encode registers, one result per cell, in
// order. The three register stages each hold one cell; a stage refills in the
// same cycle it hands its cell on, so with the output ready held high the
// throughput is one cell per cycle, and a stalled output fills the stages
// before input ready drops. Threshold registers are written through the
// write port and should only change while no cell is in flight.
module terrain_cell_obstacle_classifier_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    tcoc_cell_if.sink    i_cell,
    tcoc_class_if.source o_class
);
    import tcoc_pkg::*;

    `include "terrain_cell_obstacle_classifier_core_assert.svh"

    t_cfg    r_cfg;
    t_cell   cell_beat;
    t_cmp    cmp;
    t_dec    dec;
    t_result result;
    logic    cmp_valid;
    logic    cmp_ready;
    logic    dec_valid;
    logic    dec_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_evidence         <= RST_MIN_EVIDENCE;
            r_cfg.min_points           <= RST_MIN_POINTS;
            r_cfg.clear_floor          <= RST_CLEAR_FLOOR;
            r_cfg.overhead_clear_level <= RST_OVH_CLEAR;
            r_cfg.rise_limit           <= RST_RISE_LIMIT;
            r_cfg.drop_limit           <= RST_DROP_LIMIT;
            r_cfg.max_slope            <= RST_MAX_SLOPE;
            r_cfg.max_roughness        <= RST_MAX_ROUGHNESS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_EVIDENCE:  r_cfg.min_evidence         <= i_cfg_data;
                CFG_MIN_POINTS:    r_cfg.min_points           <= i_cfg_data[7:0];
                CFG_CLEAR_FLOOR:   r_cfg.clear_floor          <= i_cfg_data[14:0];
                CFG_OVH_CLEAR:     r_cfg.overhead_clear_level <= i_cfg_data;
                CFG_RISE_LIMIT:    r_cfg.rise_limit           <= i_cfg_data[14:0];
                CFG_DROP_LIMIT:    r_cfg.drop_limit           <= i_cfg_data[14:0];
                CFG_MAX_SLOPE:     r_cfg.max_slope            <= i_cfg_data[13:0];
                CFG_MAX_ROUGHNESS: r_cfg.max_roughness        <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        cell_beat.protrusion_level  = i_cell.protrusion_level;
        cell_beat.overhead_level    = i_cell.overhead_level;
        cell_beat.overhead_trust    = i_cell.overhead_trust;
        cell_beat.clearance_mm      = i_cell.clearance_mm;
        cell_beat.slope_cdeg        = i_cell.slope_cdeg;
        cell_beat.rise_mm           = i_cell.rise_mm;
        cell_beat.drop_mm           = i_cell.drop_mm;
        cell_beat.rough_level       = i_cell.rough_level;
        cell_beat.protrusion_rel_mm = i_cell.protrusion_rel_mm;
        cell_beat.candidate_rel_mm  = i_cell.candidate_rel_mm;
        cell_beat.sample_count      = i_cell.sample_count;
        cell_beat.frame_gain        = i_cell.frame_gain;
    end

    tcoc_compare u_compare (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_cell.valid),
        .i_cell  (cell_beat),
        .o_ready (i_cell.ready),
        .i_ready (cmp_ready),
        .o_valid (cmp_valid),
        .o_cmp   (cmp)
    );

    tcoc_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (cmp_valid),
        .i_cmp   (cmp),
        .o_ready (cmp_ready),
        .i_ready (dec_ready),
        .o_valid (dec_valid),
        .o_dec   (dec)
    );

    tcoc_encode u_encode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dec_valid),
        .i_dec    (dec),
        .o_ready  (dec_ready),
        .i_ready  (o_class.ready),
        .o_valid  (o_class.valid),
        .o_result (result)
    );

    assign o_class.blk_cause  = result.blk_cause;
    assign o_class.prot_grade = result.prot_grade;
    assign o_class.ovh_grade  = result.ovh_grade;
    assign o_class.pub_code   = result.pub_code;

    // a cell with no blocking reason publishes nothing
    `TCOC_ASSERT_IMPLIES(a_none_unpublished, i_clk, i_rst_n,
        o_class.valid && (o_class.blk_cause == REASON_NONE),
        o_class.pub_code == PUB_NA)

    // blocking protrusion always yields a geometry, protrusion or mixed reason
    `TCOC_ASSERT_IMPLIES(a_prot_block_reason, i_clk, i_rst_n,
        o_class.valid && (o_class.prot_grade == STAGE_BLOCK),
        (o_class.blk_cause == REASON_GEOMETRY) || (o_class.blk_cause == REASON_PROTRUSION)
        || (o_class.blk_cause == REASON_MIXED))

    // blocking overhead means low clearance drives the reason
    `TCOC_ASSERT_IMPLIES(a_ovh_block_reason, i_clk, i_rst_n,
        o_class.valid && (o_class.ovh_grade == STAGE_BLOCK),
        (o_class.blk_cause == REASON_LOW_CLEAR) || (o_class.blk_cause == REASON_MIXED))

    // a full pipe with a stalled output must hold off the input side
    `TCOC_ASSERT_IMPLIES(a_full_backpressure, i_clk, i_rst_n,
        o_class.valid && !o_class.ready && dec_valid && cmp_valid,
        !i_cell.ready)

    // a stalled output beat stays offered
    `TCOC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_class.valid && !o_class.ready,
        o_class.valid)
endmodule
